// ===== design/assert_macros.svh =====
// assertion macros shared by the rtl modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked at every edge outside reset
`define ASSERT_RST(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// checked at every edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== design/dqe_pkg.sv =====
// package: constants, types and control structs of the qname label encoder
`default_nettype none

package dqe_pkg;

   localparam int LABEL_MAX   = 62;
   localparam int STORE_DEPTH = 62;
   localparam int CNT_W       = $clog2(LABEL_MAX + 1);
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam logic [7:0] DOT_CHAR = 8'h2E;
   localparam logic [7:0] TERM_BYTE = 8'h00;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LEN,
      ST_CHARS,
      ST_TERM
   } state_type;

   typedef enum logic [1:0] {
      SEL_LEN,
      SEL_CHAR,
      SEL_ZERO
   } out_sel_type;

   typedef struct packed {
      logic        store;
      logic        set_ovf;
      logic        rd_first;
      logic        rd_next;
      logic        clear_count;
      out_sel_type sel;
   } dp_cmd_type;

   typedef struct packed {
      logic is_dot;
      logic count_zero;
      logic count_full;
      logic rd_end;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== design/dqe_datapath.sv =====
// datapath: label store, count, read pointer, overflow flag and output byte mux
`default_nettype none
`include "assert_macros.svh"

module dqe_datapath
   import dqe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic [7:0]    char_in,
   input  wire dp_cmd_type    cmd,
   output dp_status_type      status,
   output logic [7:0]         byte_out,
   output logic               label_error
);

   logic [7:0]        store_mem [STORE_DEPTH];
   logic [7:0]        rd_data_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;
   logic [CNT_W-1:0]  rd_idx_ff;
   logic [CNT_W-1:0]  rd_idx_in;
   logic              ovf_ff;
   logic              ovf_in;

   // label store, written at the current count, read at the read pointer
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         store_mem[count_ff[ADDR_W-1:0]] <= char_in;
      end
      if (cmd.rd_first) begin
         rd_data_ff <= store_mem['0];
      end else if (cmd.rd_next) begin
         rd_data_ff <= store_mem[rd_idx_ff[ADDR_W-1:0]];
      end
   end

   always_comb begin
      count_in  = count_ff;
      rd_idx_in = rd_idx_ff;
      ovf_in    = ovf_ff | cmd.set_ovf;
      if (cmd.clear_count) begin
         count_in = '0;
      end else if (cmd.store) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (cmd.rd_first) begin
         rd_idx_in = CNT_W'(1);
      end else if (cmd.rd_next) begin
         rd_idx_in = rd_idx_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         rd_idx_ff <= '0;
         ovf_ff    <= 1'b0;
      end else begin
         count_ff  <= count_in;
         rd_idx_ff <= rd_idx_in;
         ovf_ff    <= ovf_in;
      end
   end

   always_comb begin
      status.is_dot     = (char_in == DOT_CHAR);
      status.count_zero = (count_ff == '0);
      status.count_full = (count_ff == CNT_W'(LABEL_MAX));
      status.rd_end     = (rd_idx_ff == count_ff);
   end

   always_comb begin
      case (cmd.sel)
         SEL_LEN:  byte_out = 8'(count_ff);
         SEL_CHAR: byte_out = rd_data_ff;
         SEL_ZERO: byte_out = TERM_BYTE;
         default:  byte_out = TERM_BYTE;
      endcase
   end

   assign label_error = ovf_ff;

   `ASSERT_RST(a_count_bound, clock, reset, count_ff <= CNT_W'(LABEL_MAX), "label count past max")
   `ASSERT_RST(a_ovf_sticky, clock, reset, ovf_ff |=> ovf_ff, "overflow flag dropped")
   `ASSERT_RST(a_no_store_full, clock, reset, !(cmd.store && status.count_full),
               "store into full label")

endmodule

`default_nettype wire

// ===== design/dqe_ctrl.sv =====
// controller: state machine sequencing length, characters and terminator
`default_nettype none
`include "assert_macros.svh"

module dqe_ctrl
   import dqe_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_valid,
   input  wire logic          req_is_last,
   output logic               req_ready,
   output logic               rsp_valid,
   input  wire logic          rsp_ready,
   output logic               rsp_run_end,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   state_type state_ff;
   state_type state_in;
   logic      last_ff;
   logic      last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         last_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         last_ff  <= last_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      last_in     = last_ff;
      req_ready   = 1'b0;
      rsp_valid   = 1'b0;
      rsp_run_end = 1'b0;
      cmd         = '{store: 1'b0, set_ovf: 1'b0, rd_first: 1'b0, rd_next: 1'b0,
                      clear_count: 1'b0, sel: SEL_ZERO};
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               last_in = req_is_last;
               if (status.is_dot) begin
                  if (!status.count_zero) begin
                     state_in = ST_LEN;
                  end else if (req_is_last) begin
                     state_in = ST_TERM;
                  end
               end else begin
                  cmd.store   = !status.count_full;
                  cmd.set_ovf = status.count_full;
                  if (req_is_last) begin
                     state_in = ST_LEN;
                  end
               end
            end
         end
         ST_LEN: begin
            rsp_valid    = 1'b1;
            cmd.sel      = SEL_LEN;
            cmd.rd_first = 1'b1;
            if (rsp_ready) begin
               state_in = ST_CHARS;
            end
         end
         ST_CHARS: begin
            rsp_valid   = 1'b1;
            cmd.sel     = SEL_CHAR;
            rsp_run_end = status.rd_end && !last_ff;
            if (rsp_ready) begin
               if (status.rd_end) begin
                  cmd.clear_count = 1'b1;
                  state_in        = last_ff ? ST_TERM : ST_IDLE;
               end else begin
                  cmd.rd_next = 1'b1;
               end
            end
         end
         ST_TERM: begin
            rsp_valid       = 1'b1;
            rsp_run_end     = 1'b1;
            cmd.sel         = SEL_ZERO;
            if (rsp_ready) begin
               cmd.clear_count = 1'b1;
               state_in        = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   `ASSERT_RST(a_one_side, clock, reset, !(req_ready && rsp_valid),
               "input and output active together")
   `ASSERT_RST(a_chars_done, clock, reset,
               (state_ff == ST_CHARS && rsp_ready && status.rd_end) |=>
               (state_ff == ST_IDLE || state_ff == ST_TERM), "label flush did not finish")
   `ASSERT_ALWAYS(a_reset_idle, clock, reset |=> state_ff == ST_IDLE, "not idle after reset")

endmodule

`default_nettype wire

// ===== design/dns_qname_label_encoder_unit.sv =====
// top level: dotted hostname to dns wire form label encoder
//
//  channel | ports                                         | direction
//  --------+-----------------------------------------------+----------
//  req     | req_valid req_ready req_char_in req_is_last   | in
//  rsp     | rsp_valid rsp_ready rsp_byte_out rsp_run_end  | out
//          | rsp_label_error                               |
//
// a character that is not a dot and not last is taken and gives no transfer
// a flushed label of n characters gives n + 1 output transfers, plus the terminator if it was last,
//   starting in the cycle after the flushing item is taken; input is taken again
//   in the cycle right after the final output transfer
// the label store is read one entry per output transfer through its registered read port
// reset is synchronous: count, overflow flag and state machine clear; the store is not cleared
// a stall on rsp holds the current byte; no input is taken while a flush is in progress
`default_nettype none

module dns_qname_label_encoder_unit
   import dqe_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_char_in,
   input  wire logic       req_is_last,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_byte_out,
   output logic            rsp_run_end,
   output logic            rsp_label_error
);

   // command and status between controller and datapath
   dp_cmd_type    cmd;
   dp_status_type status;

   // state machine: accepts characters, then walks length, characters, terminator
   dqe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_is_last (req_is_last),
      .req_ready   (req_ready),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_run_end (rsp_run_end),
      .status      (status),
      .cmd         (cmd)
   );

   // label store, counters, sticky overflow flag and output byte select
   dqe_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .char_in     (req_char_in),
      .cmd         (cmd),
      .status      (status),
      .byte_out    (rsp_byte_out),
      .label_error (rsp_label_error)
   );

endmodule

`default_nettype wire
